FILE: hw/rtl/msp_pkg.sv
// ----------------------------------------------------------------------------
// msp_pkg: shared types and constants of the MSP request framer
// Request and result structs, the job record passed from front to back,
// and the header characters of a request frame.
// ----------------------------------------------------------------------------
`default_nettype none

package msp_pkg;

    // opcode of a request
    localparam logic OP_START = 1'b0;
    localparam logic OP_DATA  = 1'b1;

    // frame header characters
    localparam logic [7:0] HDR_DOLLAR = 8'h24;
    localparam logic [7:0] HDR_M      = 8'h4D;
    localparam logic [7:0] HDR_LT     = 8'h3C;

    // byte positions within a start job
    localparam logic [2:0] STEP_DOLLAR = 3'd0;
    localparam logic [2:0] STEP_M      = 3'd1;
    localparam logic [2:0] STEP_LT     = 3'd2;
    localparam logic [2:0] STEP_LEN    = 3'd3;
    localparam logic [2:0] STEP_CMD    = 3'd4;
    localparam logic [2:0] STEP_CSUM   = 3'd5;

    // byte positions within a payload job
    localparam logic [2:0] STEP_DATA     = 3'd0;
    localparam logic [2:0] STEP_DATA_SUM = 3'd1;

    typedef struct packed {
        logic       opcode;
        logic [7:0] command;
        logic [7:0] payload_length;
        logic [7:0] data_byte;
    } msp_req_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       frame_end;
    } msp_rsp_t;

    // one classified request, ready for serialization
    typedef struct packed {
        logic       is_start;
        logic [7:0] len;
        logic [7:0] val;       // command on start jobs, payload byte otherwise
        logic [7:0] csum;      // checksum after this job
        logic       has_csum;  // job closes the frame
    } msp_job_t;

endpackage

`default_nettype wire

FILE: hw/rtl/msp_front.sv
// ----------------------------------------------------------------------------
// msp_front: request classifier
// Accepts requests, tracks the open frame and checksum, and queues one job
// per request that produces output.
// ----------------------------------------------------------------------------
`default_nettype none

module msp_front
    import msp_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     push,
    input  wire msp_req_t req,
    input  wire logic     job_full,
    output logic          job_push,
    output msp_job_t      job
);

    logic [7:0] running_xor_reg;
    logic [7:0] bytes_left_reg;
    logic       frame_open_reg;

    logic       is_start;
    logic       accept;
    logic [7:0] left_dec;

    // classify the request and build its job
    always_comb
    begin
        is_start     = (req.opcode == OP_START);
        accept       = push && !job_full;
        left_dec     = bytes_left_reg - 8'd1;
        job.is_start = is_start;
        job.len      = req.payload_length;
        if (is_start)
        begin
            job.val      = req.command;
            job.csum     = req.payload_length ^ req.command;
            job.has_csum = (req.payload_length == 8'd0);
        end
        else
        begin
            job.val      = req.data_byte;
            job.csum     = running_xor_reg ^ req.data_byte;
            job.has_csum = (left_dec == 8'd0);
        end
        // drop payload with no frame open
        job_push = accept && (is_start || frame_open_reg);
    end

    // advance frame state on every queued job
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_xor_reg <= 8'd0;
            bytes_left_reg  <= 8'd0;
            frame_open_reg  <= 1'b0;
        end
        else if (job_push)
        begin
            running_xor_reg <= job.csum;
            bytes_left_reg  <= is_start ? req.payload_length : left_dec;
            frame_open_reg  <= !job.has_csum;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/msp_job_fifo.sv
// ----------------------------------------------------------------------------
// msp_job_fifo: job queue
// Small first-in first-out queue of jobs between classifier and serializer.
// ----------------------------------------------------------------------------
`default_nettype none

module msp_job_fifo
    import msp_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     wr_en,
    input  wire msp_job_t wr_job,
    input  wire logic     rd_en,
    output msp_job_t      rd_job,
    output logic          full,
    output logic          empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    msp_job_t      mem [DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] rd_ptr_reg;
    logic [CW-1:0] count_reg;

    logic          do_wr;
    logic          do_rd;

    assign full   = (count_reg == FULL_CNT);
    assign empty  = (count_reg == '0);
    assign do_wr  = wr_en && !full;
    assign do_rd  = rd_en && !empty;
    assign rd_job = mem[rd_ptr_reg];

    // store incoming jobs
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wr_ptr_reg] <= wr_job;
        end
    end

    // advance pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PW'(1);
            end
            if (do_rd)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PW'(1);
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= count_reg + CW'(1);
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= count_reg - CW'(1);
            end
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/msp_back.sv
// ----------------------------------------------------------------------------
// msp_back: frame serializer
// Walks the head job byte by byte into a one-entry output register.
// ----------------------------------------------------------------------------
`default_nettype none

module msp_back
    import msp_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire msp_job_t job,
    input  wire logic     job_empty,
    output logic          job_pop,
    input  wire logic     pop,
    output logic          empty,
    output msp_rsp_t      rsp
);

    logic [2:0] step_reg;
    logic       out_valid_reg;
    msp_rsp_t   rsp_reg;

    logic       advance;
    logic       emit;
    logic       last_step;
    logic [7:0] sel_byte;

    // pick the byte for the current step
    always_comb
    begin
        advance = !out_valid_reg || pop;
        emit    = advance && !job_empty;
        if (job.is_start)
        begin
            last_step = (step_reg == (job.has_csum ? STEP_CSUM : STEP_CMD));
            case (step_reg)
                STEP_DOLLAR: sel_byte = HDR_DOLLAR;
                STEP_M:      sel_byte = HDR_M;
                STEP_LT:     sel_byte = HDR_LT;
                STEP_LEN:    sel_byte = job.len;
                STEP_CMD:    sel_byte = job.val;
                default:     sel_byte = job.csum;
            endcase
        end
        else
        begin
            last_step = (step_reg == (job.has_csum ? STEP_DATA_SUM : STEP_DATA));
            sel_byte  = (step_reg == STEP_DATA) ? job.val : job.csum;
        end
        job_pop = emit && last_step;
    end

    assign empty = !out_valid_reg;
    assign rsp   = rsp_reg;

    // hold step and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= STEP_DOLLAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (emit)
            begin
                step_reg      <= last_step ? STEP_DOLLAR : step_reg + 3'd1;
                out_valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // load the output byte
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            rsp_reg.out_byte  <= sel_byte;
            rsp_reg.frame_end <= last_step && job.has_csum;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/msp_request_framer.sv
// ----------------------------------------------------------------------------
// msp_request_framer: MSP v1 request frame builder
// Turns start and payload requests into the byte stream of a request frame.
// ----------------------------------------------------------------------------
// Usage:
//   Request side is a queue: drive req and raise push; the request is taken
//   on a clock edge with push high and full low. A start request yields
//   '$' 'M' '<' length command, plus the checksum byte when length is zero.
//   Each payload request yields its byte, plus the checksum (frame_end set)
//   after the last one. Payload with no frame open is dropped; a start
//   request abandons any open frame.
//   Result side is a queue: rsp is valid while empty is low, and is taken
//   on an edge with pop high and empty low.
//   With the queue and output idle, an accepted request is first written into
//   the job queue, then its first byte is loaded into the output register. The
//   output emits one byte per cycle while pop keeps it drained; a start request
//   yields five or six bytes and a closing payload two, and the job queue
//   (FIFO_DEPTH entries) absorbs requests meanwhile.
//   When pop stays low the output byte holds and the queue fills; full then
//   rises. Reset clears the frame state, the queue and the output valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module msp_request_framer
    import msp_pkg::*;
#(
    parameter int FIFO_DEPTH = 4
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     push,
    output logic          full,
    input  wire msp_req_t req,
    output logic          empty,
    input  wire logic     pop,
    output msp_rsp_t      rsp
);

    msp_job_t job_in;
    msp_job_t job_head;
    logic     job_push;
    logic     job_pop;
    logic     job_full;
    logic     job_empty;

    assign full = job_full;

    // classify requests
    msp_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .req      (req),
        .job_full (job_full),
        .job_push (job_push),
        .job      (job_in)
    );

    // decouple classifier from serializer
    msp_job_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (job_push),
        .wr_job (job_in),
        .rd_en  (job_pop),
        .rd_job (job_head),
        .full   (job_full),
        .empty  (job_empty)
    );

    // serialize frames
    msp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job       (job_head),
        .job_empty (job_empty),
        .job_pop   (job_pop),
        .pop       (pop),
        .empty     (empty),
        .rsp       (rsp)
    );

    // a start request always queues a job
    a_start_queues: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !full && req.opcode == OP_START) |-> job_push)
        else $error("start request not queued");

    // a start job holds the queue for at least five output bytes
    a_start_stays: assert property (@(posedge clk) disable iff (!rst_n)
        (job_push && job_in.is_start) |=> !job_empty)
        else $error("start job left the queue too early");

    // a job leaves only with a byte going to the output
    a_pop_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
        job_pop |=> !empty)
        else $error("job retired without output byte");

endmodule

`default_nettype wire

FILE: bench/msp_frame_checker.sv
// ----------------------------------------------------------------------------
// msp_frame_checker: result checker for the MSP request framer
// Watches both queue ports, builds the expected frame bytes for every accepted
// request and compares each popped byte, in order, against them.
// ----------------------------------------------------------------------------
module msp_frame_checker
    import msp_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     push,
    input  wire logic     full,
    input  wire msp_req_t req,
    input  wire logic     empty,
    input  wire logic     pop,
    input  wire msp_rsp_t rsp,
    output int            mismatches,
    output int            pending,
    output int            checked,
    output int            frames_closed
);
    timeunit 1ns;
    timeprecision 1ps;

    // bytes the framer still owes, oldest first
    msp_rsp_t   expected_bytes[$];

    // shadow frame state
    logic [7:0] csum_acc;
    logic [7:0] remaining;
    logic       in_frame;

    int         fail_total;
    int         checked_total;
    int         closed_total;

    // append one expected byte
    task automatic queue_byte(input logic [7:0] value, input logic last);
        msp_rsp_t item;
        item.out_byte  = value;
        item.frame_end = last;
        expected_bytes.insert(expected_bytes.size(), item);
    endtask

    // advance the shadow state by one request and queue the bytes it yields
    task automatic frame_bytes_for(input msp_req_t r);
        if (r.opcode == OP_START)
        begin
            queue_byte(HDR_DOLLAR, 1'b0);
            queue_byte(HDR_M, 1'b0);
            queue_byte(HDR_LT, 1'b0);
            queue_byte(r.payload_length, 1'b0);
            queue_byte(r.command, 1'b0);
            csum_acc  = r.payload_length ^ r.command;
            remaining = r.payload_length;
            if (r.payload_length == 8'd0)
            begin
                queue_byte(csum_acc, 1'b1);
                in_frame = 1'b0;
            end
            else
            begin
                in_frame = 1'b1;
            end
        end
        // payload with no frame open is dropped
        else if (in_frame)
        begin
            queue_byte(r.data_byte, 1'b0);
            csum_acc  = csum_acc ^ r.data_byte;
            remaining = remaining - 8'd1;
            if (remaining == 8'd0)
            begin
                queue_byte(csum_acc, 1'b1);
                in_frame = 1'b0;
            end
        end
    endtask

    // compare the popped byte with the oldest expectation
    task automatic check_byte(input msp_rsp_t got);
        msp_rsp_t want;
        if (expected_bytes.size() == 0)
        begin
            fail_total++;
            if (fail_total <= 10)
                $display("%0t: unexpected result byte %02h end %0b",
                         $realtime, got.out_byte, got.frame_end);
        end
        else
        begin
            want = expected_bytes.pop_front();
            checked_total++;
            if (want.frame_end)
                closed_total++;
            if (got.out_byte !== want.out_byte || got.frame_end !== want.frame_end)
            begin
                fail_total++;
                if (fail_total <= 10)
                    $display("%0t: result %0d: expected %02h end %0b, got %02h end %0b",
                             $realtime, checked_total, want.out_byte, want.frame_end,
                             got.out_byte, got.frame_end);
            end
        end
    endtask

    // sample both handshakes at each edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_bytes.delete();
            csum_acc      = 8'd0;
            remaining     = 8'd0;
            in_frame      = 1'b0;
            fail_total    = 0;
            checked_total = 0;
            closed_total  = 0;
            mismatches    <= 0;
            pending       <= 0;
            checked       <= 0;
            frames_closed <= 0;
        end
        else
        begin
            if (pop && !empty)
                check_byte(rsp);
            if (push && !full)
                frame_bytes_for(req);
            mismatches    <= fail_total;
            pending       <= expected_bytes.size();
            checked       <= checked_total;
            frames_closed <= closed_total;
        end
    end

endmodule

FILE: bench/tb_msp_request_framer.sv
// ----------------------------------------------------------------------------
// tb_msp_request_framer: testbench for the MSP request framer
// Drives start and payload requests with random gaps and random result-side
// stalls; the checker beside the block predicts and compares every frame byte.
// ----------------------------------------------------------------------------
module tb_msp_request_framer
    import msp_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TOTAL_ITEMS = 310;
    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_EVERY = 80;

    logic     clk   = 1'b0;
    logic     rst_n = 1'b0;
    logic     push  = 1'b0;
    logic     pop   = 1'b0;
    msp_req_t req   = '0;
    logic     full;
    logic     empty;
    msp_rsp_t rsp;

    int       mismatches;
    int       pending;
    int       checked;
    int       frames_closed;

    // stimulus bookkeeping
    int       open_left  = 0;
    int       counted    = 0;
    int       starts     = 0;
    int       payloads   = 0;
    int       dropped    = 0;
    int       abandoned  = 0;
    bit       send_calm  = 1'b0;
    int       idle_cycles = 0;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    msp_request_framer i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .full  (full),
        .req   (req),
        .empty (empty),
        .pop   (pop),
        .rsp   (rsp)
    );

    msp_frame_checker i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .req           (req),
        .empty         (empty),
        .pop           (pop),
        .rsp           (rsp),
        .mismatches    (mismatches),
        .pending       (pending),
        .checked       (checked),
        .frames_closed (frames_closed)
    );

    // gap length: mostly none or short, now and then long
    function automatic int idle_len(input bit calm);
        int roll;
        if (calm)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 88)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic msp_req_t start_req(input logic [7:0] cmd, input logic [7:0] len);
        msp_req_t r;
        r.opcode         = OP_START;
        r.command        = cmd;
        r.payload_length = len;
        r.data_byte      = 8'($urandom_range(0, 255));
        return r;
    endfunction

    function automatic msp_req_t data_req(input logic [7:0] value);
        msp_req_t r;
        r.opcode         = OP_DATA;
        r.command        = 8'($urandom_range(0, 255));
        r.payload_length = 8'($urandom_range(0, 255));
        r.data_byte      = value;
        return r;
    endfunction

    // hand one request to the block, track frame state, then idle a while
    task automatic issue(input msp_req_t r);
        int gap;
        counted++;
        if (r.opcode == OP_START)
        begin
            if (open_left != 0)
                abandoned++;
            open_left = r.payload_length;
            starts++;
        end
        else
        begin
            payloads++;
            if (open_left == 0)
            begin
                dropped++;
            end
            else
            begin
                open_left--;
            end
        end
        req  <= r;
        push <= 1'b1;
        @(posedge clk);
        while (full)
            @(posedge clk);
        gap = idle_len(send_calm);
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // hold the sender until every expected byte has been popped
    task automatic wait_results_drained();
        push <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    function automatic int pick_length();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 10)
            return 0;
        if (roll < 85)
            return $urandom_range(1, 6);
        return $urandom_range(7, 20);
    endfunction

    // result side: random pop stalls with calm stretches
    initial
    begin : result_side
        int hold;
        int stretch;
        bit calm;
        calm    = 1'b0;
        stretch = 0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (stretch == 0)
            begin
                calm    = ($urandom_range(0, 3) == 0);
                stretch = $urandom_range(10, 60);
            end
            stretch--;
            hold = idle_len(calm);
            if (hold > 0)
            begin
                pop <= 1'b0;
                repeat (hold) @(posedge clk);
            end
            pop <= 1'b1;
            @(posedge clk);
        end
    end

    // watchdog: end the run when nothing moves for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((push && !full) || (pop && !empty))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("%0t: nothing accepted for %0d cycles", $realtime, STALL_LIMIT);
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        int len;
        int cut;
        int kind;
        int next_drain;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: drops, zero-length frames, extremes, abandoned frames
        issue(data_req(8'hFF));
        issue(start_req(8'h00, 8'h00));
        issue(start_req(8'hFF, 8'h00));
        issue(start_req(8'h64, 8'h01));
        issue(data_req(8'hAA));
        issue(start_req(8'h55, 8'hFF));
        issue(data_req(8'h00));
        issue(data_req(8'hFF));
        issue(start_req(8'hC8, 8'h02));
        issue(data_req(8'h01));
        issue(data_req(8'h80));
        issue(data_req(8'h7F));
        issue(start_req(8'h6C, 8'h03));
        issue(data_req(8'h12));
        issue(start_req(8'hA5, 8'h00));
        issue(data_req(8'h33));
        wait_results_drained();

        // random: mostly whole frames, some cut short, some stray payload
        next_drain = counted + DRAIN_EVERY;
        while (counted < TOTAL_ITEMS)
        begin
            send_calm = ($urandom_range(0, 4) == 0);
            kind      = $urandom_range(0, 99);
            if (kind < 75)
            begin
                len = pick_length();
                issue(start_req(8'($urandom_range(0, 255)), 8'(len)));
                repeat (len) issue(data_req(8'($urandom_range(0, 255))));
            end
            else if (kind < 90)
            begin
                len = $urandom_range(1, 255);
                cut = $urandom_range(0, (len > 4) ? 4 : len - 1);
                issue(start_req(8'($urandom_range(0, 255)), 8'(len)));
                repeat (cut) issue(data_req(8'($urandom_range(0, 255))));
            end
            else
            begin
                repeat ($urandom_range(1, 3)) issue(data_req(8'($urandom_range(0, 255))));
            end
            if (counted >= next_drain)
            begin
                wait_results_drained();
                next_drain = counted + DRAIN_EVERY;
            end
        end

        // drain, then allow for the pipeline latency
        send_calm = 1'b0;
        wait_results_drained();
        repeat (8) @(posedge clk);

        $display("Covered %0d starts (%0d abandoned), %0d payload requests (%0d dropped).",
                 starts, abandoned, payloads, dropped);
        $display("Compared %0d result bytes; %0d frames closed with a checksum.",
                 checked, frames_closed);
        if (mismatches == 0 && pending == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
